@@ src/mfc_pkg.sv @@
`timescale 1ns / 1ps

package mfc_pkg;

    // CRC-16 settings
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Byte positions within the frame
    localparam logic [5:0] POS_IDLE   = 6'd38;
    localparam logic [5:0] POS_FIRST  = 6'd1;
    localparam logic [5:0] POS_VER    = 6'd1;
    localparam logic [5:0] POS_PROT   = 6'd2;
    localparam logic [5:0] POS_MODE   = 6'd3;
    localparam logic [5:0] SIDE_START = 6'd6;

    // Two-bit field value for MPEG-1 (version) and for mono (mode)
    localparam logic [1:0] FIELD_SET = 2'b11;

    // Side-info lengths in bytes
    localparam logic [5:0] SIDE_LEN_MPEG1_STEREO = 6'd32;
    localparam logic [5:0] SIDE_LEN_MPEG1_MONO   = 6'd17;
    localparam logic [5:0] SIDE_LEN_MPEG2_STEREO = 6'd17;
    localparam logic [5:0] SIDE_LEN_MPEG2_MONO   = 6'd9;
    localparam logic [5:0] SIDE_LEN_RESET        = 6'd17;

    // One frame byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } byte_word_t;

    // One CRC result
    typedef struct packed {
        logic [15:0] crc_value;
        logic [5:0]  side_info_bytes;
    } crc_word_t;

    // Byte-wide CRC update, MSB first; eight shift steps unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/mp3_frame_crc16_core.sv @@
`timescale 1ns / 1ps
// Latency: a result word appears in the cycle after the last side-info byte is taken.
// Throughput: one byte per cycle; the byte-wide CRC update and position counter
// are combinational logic between the state registers and the result register.
// A new byte is held off only when it would produce a result while the previous
// result is still stalled. Reset (rst_n low, asynchronous) sets the CRC to 0xFFFF,
// the position to idle, the side-info length to 17 and clears the result valid.
module mp3_frame_crc16_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  mfc_pkg::byte_word_t byte_word,
    output logic               crc_valid,
    input  logic               crc_stall,
    output mfc_pkg::crc_word_t  crc_word
);

    // Frame tracking state
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [5:0]  pos_reg;
    logic [5:0]  pos_next;
    logic        mpeg1_reg;
    logic        mpeg1_next;
    logic [5:0]  side_len_reg;
    logic [5:0]  side_len_next;

    // Result register
    logic                crc_valid_reg;
    mfc_pkg::crc_word_t  crc_word_reg;

    logic        take;
    logic        emit;
    logic        mono;
    logic [15:0] crc_upd;
    logic [5:0]  last_pos;

    assign mono     = (byte_word.data_byte[7:6] == mfc_pkg::FIELD_SET);
    assign crc_upd  = mfc_pkg::crc_byte(crc_reg, byte_word.data_byte);
    assign last_pos = mfc_pkg::SIDE_START + side_len_reg - 6'd1;

    // Byte that closes the side info (only valid in the side-info range)
    assign emit = !byte_word.frame_start && (pos_reg < mfc_pkg::POS_IDLE)
                  && (pos_reg >= mfc_pkg::SIDE_START) && (pos_reg >= last_pos);

    // Only a result-producing byte waits for a stalled result
    assign byte_stall = crc_valid_reg && crc_stall && emit;
    assign take       = byte_valid && !byte_stall;

    // Next-state logic for one byte
    always_comb
    begin
        crc_next      = crc_reg;
        pos_next      = pos_reg;
        mpeg1_next    = mpeg1_reg;
        side_len_next = side_len_reg;
        priority if (byte_word.frame_start)
        begin
            crc_next = mfc_pkg::CRC_INIT;
            pos_next = mfc_pkg::POS_FIRST;
        end
        else if (pos_reg >= mfc_pkg::POS_IDLE)
        begin
            pos_next = pos_reg;
        end
        else
        begin
            pos_next = pos_reg + 6'd1;
            priority if (pos_reg == mfc_pkg::POS_VER)
            begin
                mpeg1_next = (byte_word.data_byte[4:3] == mfc_pkg::FIELD_SET);
            end
            else if (pos_reg == mfc_pkg::POS_PROT)
            begin
                crc_next = crc_upd;
            end
            else if (pos_reg == mfc_pkg::POS_MODE)
            begin
                crc_next = crc_upd;
                if (mpeg1_reg)
                begin
                    side_len_next = mono ? mfc_pkg::SIDE_LEN_MPEG1_MONO
                                         : mfc_pkg::SIDE_LEN_MPEG1_STEREO;
                end
                else
                begin
                    side_len_next = mono ? mfc_pkg::SIDE_LEN_MPEG2_MONO
                                         : mfc_pkg::SIDE_LEN_MPEG2_STEREO;
                end
            end
            else if (pos_reg >= mfc_pkg::SIDE_START)
            begin
                crc_next = crc_upd;
                if (emit)
                begin
                    pos_next = mfc_pkg::POS_IDLE;
                end
            end
            else
            begin
                // bytes 0, 4 and 5 stay out of the CRC and only advance
                crc_next = crc_reg;
            end
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= mfc_pkg::CRC_INIT;
            pos_reg       <= mfc_pkg::POS_IDLE;
            mpeg1_reg     <= 1'b0;
            side_len_reg  <= mfc_pkg::SIDE_LEN_RESET;
            crc_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                crc_reg      <= crc_next;
                pos_reg      <= pos_next;
                mpeg1_reg    <= mpeg1_next;
                side_len_reg <= side_len_next;
            end
            if (take && emit)
            begin
                crc_valid_reg <= 1'b1;
            end
            else if (!crc_stall)
            begin
                crc_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            crc_word_reg.crc_value       <= crc_upd;
            crc_word_reg.side_info_bytes <= side_len_reg;
        end
    end

    assign crc_valid = crc_valid_reg;
    assign crc_word  = crc_word_reg;

    // Checks

    // Position never leaves the frame range
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= mfc_pkg::POS_IDLE)
        else $error("byte position out of range");

    // A start byte always restarts at byte 1 with a fresh CRC
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && byte_word.frame_start) |=> (pos_reg == mfc_pkg::POS_FIRST)
                                            && (crc_reg == mfc_pkg::CRC_INIT))
        else $error("start byte did not restart frame");

    // Emitting a result sends the block idle and shows a valid result
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit) |=> (pos_reg == mfc_pkg::POS_IDLE) && crc_valid_reg)
        else $error("result emit did not go idle");

    // A result word always carries one of the three side-info lengths
    a_side_len: assert property (@(posedge clk) disable iff (!rst_n)
        crc_valid_reg |-> (crc_word_reg.side_info_bytes == mfc_pkg::SIDE_LEN_MPEG2_MONO)
                       || (crc_word_reg.side_info_bytes == mfc_pkg::SIDE_LEN_MPEG1_MONO)
                       || (crc_word_reg.side_info_bytes == mfc_pkg::SIDE_LEN_MPEG1_STEREO))
        else $error("bad side-info length in result");

    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (crc_valid_reg && crc_stall) |-> !(take && emit))
        else $error("stalled result overwritten");

endmodule
